@@ rtl/bsa_pkg.sv @@
// Package for the BMP scaled source address block: widths, register map, beat types, helpers.
package bsa_pkg;

    // Dimension width; the other widths follow from it
    localparam int DIM_BITS  = 12;
    localparam int START_W   = DIM_BITS;           // rectangle start
    localparam int SIZE_W    = DIM_BITS + 1;       // coordinates, sizes, widths
    localparam int HGT_W     = DIM_BITS + 2;       // signed image height
    localparam int QUO_W     = HGT_W;              // scaled row/column
    localparam int DIVW      = SIZE_W + QUO_W;     // dividend and remainder
    localparam int ROW_W     = HGT_W + 1;          // signed flipped row
    localparam int RB_W      = SIZE_W + 3;         // padded row bytes
    localparam int BPP_W     = 3;                  // bytes per pixel (3 or 4)
    localparam int COLB_W    = QUO_W + BPP_W;      // column byte offset
    localparam int ADDR_W    = 32;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 5;
    localparam int LATENCY   = QUO_W + 3;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;
    localparam logic [BPP_W-1:0] BYTES_3  = 3'd3;
    localparam logic [BPP_W-1:0] BYTES_4  = 3'd4;

    // Register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_FB_WIDTH     = 3'd0,
        REG_FB_HEIGHT    = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_BPP          = 3'd4,
        REG_PIXEL_OFFSET = 3'd5,
        REG_SIGNATURE    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0]        fb_width;
        logic [SIZE_W-1:0]        fb_height;
        logic [SIZE_W-1:0]        image_width;
        logic signed [HGT_W-1:0]  image_height;
        logic [15:0]              bits_per_pixel;
        logic [ADDR_W-1:0]        pixel_data_offset;
        logic [15:0]              file_signature;
    } t_cfg;

    typedef struct packed {
        logic [SIZE_W-1:0]  pixel_x;
        logic [SIZE_W-1:0]  pixel_y;
        logic [START_W-1:0] rect_x_start;
        logic [START_W-1:0] rect_y_start;
        logic [SIZE_W-1:0]  rect_width;
        logic [SIZE_W-1:0]  rect_height;
    } t_in_item;

    typedef struct packed {
        logic              draw_enable;
        logic [ADDR_W-1:0] source_byte_address;
    } t_out_item;

    // Front stage to divider
    typedef struct packed {
        logic            draw;
        logic [DIVW-1:0] num_x;
        logic [DIVW-1:0] num_y;
    } t_div_in;

    // Divider to address stage
    typedef struct packed {
        logic             draw;
        logic [QUO_W-1:0] src_x;
        logic [QUO_W-1:0] src_y;
    } t_div_out;

    // Magnitude of the raw signed height, HGT_W bits
    function automatic logic [HGT_W-1:0] f_abs_height(input logic [HGT_W-1:0] ih);
        f_abs_height = ih[HGT_W-1] ? (~ih + {{(HGT_W-1){1'b0}}, 1'b1}) : ih;
    endfunction

    // Bytes per pixel for an accepted depth
    function automatic logic [BPP_W-1:0] f_bytes_pp(input logic [15:0] bpp);
        f_bytes_pp = (bpp == BPP_32) ? BYTES_4 : BYTES_3;
    endfunction

endpackage

@@ rtl/bsa_apb_regs.sv @@
// APB configuration registers of the BMP scaled source address block.
module bsa_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsa_pkg::PADDR_W-1:0] paddr,
    input  logic [bsa_pkg::DATA_W-1:0]  pwdata,
    output logic [bsa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output bsa_pkg::t_cfg               o_cfg
);
    import bsa_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_FB_WIDTH:     r_cfg.fb_width          <= pwdata[SIZE_W-1:0];
                REG_FB_HEIGHT:    r_cfg.fb_height         <= pwdata[SIZE_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width       <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height      <= pwdata[HGT_W-1:0];
                REG_BPP:          r_cfg.bits_per_pixel    <= pwdata[15:0];
                REG_PIXEL_OFFSET: r_cfg.pixel_data_offset <= pwdata[ADDR_W-1:0];
                REG_SIGNATURE:    r_cfg.file_signature    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_FB_WIDTH:     prdata = DATA_W'(r_cfg.fb_width);
            REG_FB_HEIGHT:    prdata = DATA_W'(r_cfg.fb_height);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_cfg.image_height);
            REG_BPP:          prdata = DATA_W'(r_cfg.bits_per_pixel);
            REG_PIXEL_OFFSET: prdata = r_cfg.pixel_data_offset;
            REG_SIGNATURE:    prdata = DATA_W'(r_cfg.file_signature);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ rtl/bsa_front.sv @@
// Front stage: header and bounds checks, scaling products.
module bsa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bsa_pkg::t_in_item i_item,
    input  bsa_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output bsa_pkg::t_div_in  o_data
);
    import bsa_pkg::*;

    logic            r_valid;
    t_div_in         r_data;
    t_div_in         n_data;
    logic            w_header_ok;
    logic            w_in_x;
    logic            w_in_y;
    logic [SIZE_W:0] w_x_end;
    logic [SIZE_W:0] w_y_end;
    logic [HGT_W-1:0] w_abs_h;

    // Checks
    assign w_header_ok = (i_cfg.file_signature == BMP_SIGNATURE) &&
                         ((i_cfg.bits_per_pixel == BPP_24) ||
                          (i_cfg.bits_per_pixel == BPP_32));
    assign w_x_end = (SIZE_W+1)'(i_item.rect_x_start) + (SIZE_W+1)'(i_item.rect_width);
    assign w_y_end = (SIZE_W+1)'(i_item.rect_y_start) + (SIZE_W+1)'(i_item.rect_height);
    assign w_in_x  = (i_item.pixel_x >= SIZE_W'(i_item.rect_x_start)) &&
                     ((SIZE_W+1)'(i_item.pixel_x) < w_x_end) &&
                     (i_item.pixel_x < i_cfg.fb_width);
    assign w_in_y  = (i_item.pixel_y >= SIZE_W'(i_item.rect_y_start)) &&
                     ((SIZE_W+1)'(i_item.pixel_y) < w_y_end) &&
                     (i_item.pixel_y < i_cfg.fb_height);
    assign w_abs_h = f_abs_height(i_cfg.image_height);

    // Dividends: coordinate times image size
    always_comb begin
        n_data.draw  = w_header_ok & w_in_x & w_in_y;
        n_data.num_x = DIVW'(i_item.pixel_x) * DIVW'(i_cfg.image_width);
        n_data.num_y = DIVW'(i_item.pixel_y) * DIVW'(w_abs_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/bsa_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, column and row lanes.
module bsa_div_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bsa_pkg::t_div_in  i_data,
    input  bsa_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output bsa_pkg::t_div_out o_data
);
    import bsa_pkg::*;

    // Stage k resolves quotient bit QUO_W-1-k
    logic             r_valid [QUO_W];
    logic             r_draw  [QUO_W];
    logic [DIVW-1:0]  r_rem_x [QUO_W];
    logic [DIVW-1:0]  r_rem_y [QUO_W];
    logic [QUO_W-1:0] r_q_x   [QUO_W];
    logic [QUO_W-1:0] r_q_y   [QUO_W];
    logic [DIVW-1:0]  n_rem_x [QUO_W];
    logic [DIVW-1:0]  n_rem_y [QUO_W];
    logic [QUO_W-1:0] n_q_x   [QUO_W];
    logic [QUO_W-1:0] n_q_y   [QUO_W];

    // Compare-subtract for every stage
    always_comb begin
        logic [DIVW-1:0]  rem_x;
        logic [DIVW-1:0]  rem_y;
        logic [QUO_W-1:0] q_x;
        logic [QUO_W-1:0] q_y;
        logic [DIVW-1:0]  d_x;
        logic [DIVW-1:0]  d_y;
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                rem_x = i_data.num_x;
                rem_y = i_data.num_y;
                q_x   = '0;
                q_y   = '0;
            end else begin
                rem_x = r_rem_x[k-1];
                rem_y = r_rem_y[k-1];
                q_x   = r_q_x[k-1];
                q_y   = r_q_y[k-1];
            end
            d_x = DIVW'(i_cfg.fb_width)  << (QUO_W - 1 - k);
            d_y = DIVW'(i_cfg.fb_height) << (QUO_W - 1 - k);
            if (rem_x >= d_x) begin
                n_rem_x[k] = rem_x - d_x;
                n_q_x[k]   = {q_x[QUO_W-2:0], 1'b1};
            end else begin
                n_rem_x[k] = rem_x;
                n_q_x[k]   = {q_x[QUO_W-2:0], 1'b0};
            end
            if (rem_y >= d_y) begin
                n_rem_y[k] = rem_y - d_y;
                n_q_y[k]   = {q_y[QUO_W-2:0], 1'b1};
            end else begin
                n_rem_y[k] = rem_y;
                n_q_y[k]   = {q_y[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Stage registers; valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < QUO_W; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
        r_draw[0] <= i_data.draw;
        for (int k = 1; k < QUO_W; k++) begin
            r_draw[k] <= r_draw[k-1];
        end
        for (int k = 0; k < QUO_W; k++) begin
            r_rem_x[k] <= n_rem_x[k];
            r_rem_y[k] <= n_rem_y[k];
            r_q_x[k]   <= n_q_x[k];
            r_q_y[k]   <= n_q_y[k];
        end
    end

    assign o_valid      = r_valid[QUO_W-1];
    assign o_data.draw  = r_draw[QUO_W-1];
    assign o_data.src_x = r_q_x[QUO_W-1];
    assign o_data.src_y = r_q_y[QUO_W-1];

endmodule

@@ rtl/bsa_addr.sv @@
// Address stages: row flip, row and column byte offsets, final sum and result register.
module bsa_addr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bsa_pkg::t_div_out  i_data,
    input  bsa_pkg::t_cfg      i_cfg,
    output logic               o_done,
    output bsa_pkg::t_out_item o_result
);
    import bsa_pkg::*;

    logic                    w_top_down;
    logic [HGT_W-1:0]        w_abs_h;
    logic [BPP_W-1:0]        w_bpp;
    logic [RB_W-1:0]         w_pix_bytes;
    logic [RB_W-1:0]         w_row_bytes;
    logic signed [ROW_W-1:0] w_row;
    logic [ADDR_W-1:0]       n_row_off;
    logic [COLB_W-1:0]       n_col_off;

    logic                    r_a_valid;
    logic                    r_a_draw;
    logic [ADDR_W-1:0]       r_row_off;
    logic [COLB_W-1:0]       r_col_off;
    logic                    r_done;
    t_out_item               r_result;

    // Image geometry from the registers
    assign w_top_down  = i_cfg.image_height[HGT_W-1];
    assign w_abs_h     = f_abs_height(i_cfg.image_height);
    assign w_bpp       = f_bytes_pp(i_cfg.bits_per_pixel);
    assign w_pix_bytes = RB_W'(i_cfg.image_width) * RB_W'(w_bpp);
    assign w_row_bytes = (w_pix_bytes + RB_W'(3)) & ~RB_W'(3);

    // Row flip for bottom-up images; a zero height gives row -1
    assign w_row = w_top_down ? $signed({1'b0, i_data.src_y})
                              : $signed({1'b0, w_abs_h}) - ROW_W'(1)
                                - $signed({1'b0, i_data.src_y});

    // Row is sign-extended to the address width first, so the product wraps mod 2^32
    always_comb begin
        n_row_off = ADDR_W'(w_row) * ADDR_W'({1'b0, w_row_bytes});
        n_col_off = COLB_W'(i_data.src_x) * COLB_W'(w_bpp);
    end

    // Stage 1: offsets; stage 2: sum and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_done    <= r_a_valid;
        end
        r_a_draw  <= i_data.draw;
        r_row_off <= n_row_off;
        r_col_off <= n_col_off;
        r_result.draw_enable         <= r_a_draw;
        r_result.source_byte_address <= r_a_draw
            ? (i_cfg.pixel_data_offset + r_row_off + ADDR_W'(r_col_off))
            : '0;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/bmp_scaled_source_address.sv @@
// Top level of the BMP scaled source address block.
//
// One beat is accepted on every clock where start is high; busy is always low, so a
// coordinate can be issued every cycle. Each beat gives one result on o_result, marked by
// o_done for exactly one cycle, in issue order; the receiver must take it then. The
// pipeline is one check/multiply stage, one quotient bit per stage through the divider
// (DIM_BITS + 2 stages, column and row lanes side by side), one row offset multiply stage
// and one sum/output stage. A beat that is not drawn returns address 0. Configuration must
// be written over APB only while no beat is in flight; the block itself does not enforce
// this. The registers are read straight into every stage.
module bmp_scaled_source_address (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bsa_pkg::t_in_item           i_in,
    output logic                        o_done,
    output bsa_pkg::t_out_item          o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsa_pkg::PADDR_W-1:0] paddr,
    input  logic [bsa_pkg::DATA_W-1:0]  pwdata,
    output logic [bsa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bsa_pkg::*;

    t_cfg     w_cfg;
    logic     w_f_valid;
    t_div_in  w_f_data;
    logic     w_d_valid;
    t_div_out w_d_data;

    // Fully pipelined, never stalls
    assign busy = 1'b0;

    bsa_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_in),
        .i_cfg   (w_cfg),
        .o_valid (w_f_valid),
        .o_data  (w_f_data)
    );

    bsa_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_data  (w_f_data),
        .i_cfg   (w_cfg),
        .o_valid (w_d_valid),
        .o_data  (w_d_data)
    );

    bsa_addr u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .i_data   (w_d_data),
        .i_cfg    (w_cfg),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
